>>> hdl/lprb_pkg.sv
// shared constants and codes for the length-prefixed packet ring buffer
package lprb_pkg;

    // default ring storage depth in bytes
    localparam int BUFFER_BYTES_DEF = 4096;

    // field widths of the transfer payloads
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 2;
    localparam int BUSY_W   = 12;
    localparam int FREE_W   = 13;
    localparam int HDR_W    = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int SIZE_W     = 13;
    localparam int SIZE_MIN   = 5;
    localparam int SIZE_RESET = 4096;

    // register indexes (byte address bits above the word offset)
    localparam logic [APB_ADDR_W-3:0] REG_BUFFER_SIZE = 1'b0;

    // header length in bytes
    localparam int HDR_BYTES = 4;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DISCARD = 2'd3;

    // open block kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE   = 2'd0;
    localparam t_kind KIND_PUSH   = 2'd1;
    localparam t_kind KIND_POP    = 2'd2;
    localparam t_kind KIND_PACKET = 2'd3;

endpackage

>>> hdl/lprb_req_if.sv
// request channel carrying one byte-level command per transfer
interface lprb_req_if;
    logic                           valid;
    logic                           ready;
    logic [lprb_pkg::CMD_W-1:0]     command;
    logic [lprb_pkg::BYTE_W-1:0]    data_byte;
    logic [lprb_pkg::LEN_W-1:0]     block_length;
    logic                           block_first;

    modport source (
        output valid, command, data_byte, block_length, block_first,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, block_length, block_first,
        output ready
    );
endinterface

>>> hdl/lprb_rsp_if.sv
// result channel carrying one status and fill report per transfer
interface lprb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [lprb_pkg::STATUS_W-1:0]      status;
    logic [lprb_pkg::BYTE_W-1:0]        out_byte;
    logic                               last_byte;
    logic [lprb_pkg::BUSY_W-1:0]        busy_count;
    logic [lprb_pkg::FREE_W-1:0]        free_count;
    logic signed [lprb_pkg::HDR_W-1:0]  next_packet_length;
    logic                               packet_ready;

    modport source (
        output valid, status, out_byte, last_byte, busy_count, free_count,
               next_packet_length, packet_ready,
        input  ready
    );
    modport sink (
        input  valid, status, out_byte, last_byte, busy_count, free_count,
               next_packet_length, packet_ready,
        output ready
    );
endinterface

>>> hdl/lprb_cfg.sv
// apb register block holding the ring size
module lprb_cfg #(
    parameter int BUFFER_BYTES = lprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lprb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lprb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lprb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [$clog2(BUFFER_BYTES+1)-1:0]   o_ring,
    output logic                                o_clear
);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int VW = (CW > lprb_pkg::SIZE_W) ? CW : lprb_pkg::SIZE_W;
    localparam int RING_RESET = (lprb_pkg::SIZE_RESET > BUFFER_BYTES) ?
                                BUFFER_BYTES : lprb_pkg::SIZE_RESET;

    logic [lprb_pkg::SIZE_W-1:0] r_size;
    logic [CW-1:0]               r_ring;
    logic                        w_sel;
    logic                        w_wr;
    logic [lprb_pkg::SIZE_W-1:0] w_wsize;
    logic [VW-1:0]               w_wide;
    logic [VW-1:0]               w_clamped;

    // address decode and write strobe
    assign w_sel   = (paddr[lprb_pkg::APB_ADDR_W-1:2] == lprb_pkg::REG_BUFFER_SIZE);
    assign w_wr    = psel && penable && pwrite && w_sel;
    assign w_wsize = pwdata[lprb_pkg::SIZE_W-1:0];
    assign pready  = 1'b1;
    assign o_clear = w_wr;
    assign o_ring  = r_ring;

    // clamp the written size into the legal ring range
    always_comb begin
        w_wide = VW'(w_wsize);
        if (w_wide < VW'(lprb_pkg::SIZE_MIN)) begin
            w_clamped = VW'(lprb_pkg::SIZE_MIN);
        end else if (w_wide > VW'(BUFFER_BYTES)) begin
            w_clamped = VW'(BUFFER_BYTES);
        end else begin
            w_clamped = w_wide;
        end
    end

    // read back
    assign prdata = w_sel ? lprb_pkg::APB_DATA_W'(r_size) : '0;

    // size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= lprb_pkg::SIZE_W'(lprb_pkg::SIZE_RESET);
            r_ring <= CW'(RING_RESET);
        end else if (w_wr) begin
            r_size <= w_wsize;
            r_ring <= w_clamped[CW-1:0];
        end
    end
endmodule

>>> hdl/lprb_mem.sv
// single-port byte memory with registered read data
module lprb_mem #(
    parameter int BUFFER_BYTES = lprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(BUFFER_BYTES)-1:0]   i_addr,
    input  logic [lprb_pkg::BYTE_W-1:0]       i_wdata,
    output logic [lprb_pkg::BYTE_W-1:0]       o_rdata
);
    logic [lprb_pkg::BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [lprb_pkg::BYTE_W-1:0] r_rdata;

    // one access per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/lprb_ctrl.sv
// command sequencer: pointers, block tracking, header reads and result register
module lprb_ctrl #(
    parameter int BUFFER_BYTES = lprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lprb_req_if.sink                            i_req,
    lprb_rsp_if.source                          o_rsp,
    input  logic [$clog2(BUFFER_BYTES+1)-1:0]   i_ring,
    input  logic                                i_clear,
    output logic                                o_mem_we,
    output logic [$clog2(BUFFER_BYTES)-1:0]     o_mem_addr,
    output logic [lprb_pkg::BYTE_W-1:0]         o_mem_wdata,
    input  logic [lprb_pkg::BYTE_W-1:0]         i_mem_rdata
);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int VW = (CW > lprb_pkg::LEN_W) ? CW : lprb_pkg::LEN_W;
    localparam int BW = lprb_pkg::BYTE_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_H0   = 3'd1;
    localparam logic [2:0] S_H1   = 3'd2;
    localparam logic [2:0] S_H2   = 3'd3;
    localparam logic [2:0] S_H3   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                     r_state, n_state;
    logic [AW-1:0]                  r_rp, n_rp;
    logic [AW-1:0]                  r_wp, n_wp;
    logic [AW-1:0]                  r_hp, n_hp;
    lprb_pkg::t_kind                r_kind, n_kind;
    logic [CW-1:0]                  r_rem, n_rem;
    logic                           r_rd, n_rd;
    logic [lprb_pkg::HDR_W-1:0]     r_hdr, n_hdr;
    logic [lprb_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                           r_last, n_last;
    logic                           r_pop, n_pop;
    logic [BW-1:0]                  r_obyte, n_obyte;

    // result register
    logic                           r_ovalid, n_ovalid;
    logic [lprb_pkg::STATUS_W-1:0]  r_o_status;
    logic [BW-1:0]                  r_o_byte;
    logic                           r_o_last;
    logic [lprb_pkg::BUSY_W-1:0]    r_o_busy;
    logic [lprb_pkg::FREE_W-1:0]    r_o_free;
    logic [lprb_pkg::HDR_W-1:0]     r_o_hdr;
    logic                           r_o_ready;

    logic                           w_accept;
    logic                           w_load;
    logic [CW-1:0]                  w_busy;
    logic [CW-1:0]                  w_free;
    logic [31:0]                    w_busy32;
    logic [31:0]                    w_free32;
    logic [lprb_pkg::HDR_W-1:0]     w_hdr_new;
    logic [lprb_pkg::HDR_W-1:0]     w_hdr_out;
    logic                           w_pkt_ready;
    logic                           w_do_push;
    logic                           w_do_pop;
    logic [lprb_pkg::STATUS_W-1:0]  w_status;
    lprb_pkg::t_kind                w_kind;
    lprb_pkg::t_kind                w_pop_kind;
    logic [CW-1:0]                  w_rem;
    logic                           w_last;
    logic [VW-1:0]                  w_len;

    // step a pointer around the active ring
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p,
                                              input logic [CW-1:0] ring);
        logic [CW-1:0] nxt;
        nxt = CW'(p) + CW'(1);
        advance = (nxt >= ring) ? '0 : nxt[AW-1:0];
    endfunction

    // stored byte count and free space
    always_comb begin
        if (r_wp >= r_rp) begin
            w_busy = CW'(r_wp) - CW'(r_rp);
        end else begin
            w_busy = CW'(r_wp) + i_ring - CW'(r_rp);
        end
        w_free   = i_ring - w_busy;
        w_busy32 = 32'(w_busy);
        w_free32 = 32'(w_free);
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_len       = VW'(i_req.block_length);

    // block checks for the item at the request port
    always_comb begin
        w_status   = lprb_pkg::ST_OK;
        w_kind     = r_kind;
        w_rem      = r_rem;
        w_do_push  = 1'b0;
        w_do_pop   = 1'b0;
        w_last     = 1'b0;
        w_pop_kind = (i_req.command == lprb_pkg::CMD_POP) ?
                     lprb_pkg::KIND_POP : lprb_pkg::KIND_PACKET;
        case (i_req.command)
            lprb_pkg::CMD_PUSH: begin
                if (i_req.block_first) begin
                    w_kind = lprb_pkg::KIND_NONE;
                    w_rem  = '0;
                    if (i_req.block_length == '0) begin
                        w_status = lprb_pkg::ST_BAD_LEN;
                    end else if (VW'(w_free) <= w_len) begin
                        w_status = lprb_pkg::ST_NO_ROOM;
                    end else begin
                        w_kind = lprb_pkg::KIND_PUSH;
                        w_rem  = w_len[CW-1:0];
                    end
                end else if (!(r_kind == lprb_pkg::KIND_PUSH && r_rem != '0)) begin
                    w_status = lprb_pkg::ST_DISCARD;
                end
                if (w_status == lprb_pkg::ST_OK) begin
                    w_do_push = 1'b1;
                    w_rem     = w_rem - CW'(1);
                    if (w_rem == '0) begin
                        w_kind = lprb_pkg::KIND_NONE;
                    end
                end
            end
            lprb_pkg::CMD_POP, lprb_pkg::CMD_PACKET: begin
                if (i_req.block_first) begin
                    w_kind = lprb_pkg::KIND_NONE;
                    w_rem  = '0;
                    if (w_pop_kind == lprb_pkg::KIND_POP) begin
                        if (i_req.block_length == '0) begin
                            w_status = lprb_pkg::ST_BAD_LEN;
                        end else if (VW'(w_busy) < w_len) begin
                            w_status = lprb_pkg::ST_NO_ROOM;
                        end else begin
                            w_kind = lprb_pkg::KIND_POP;
                            w_rem  = w_len[CW-1:0];
                        end
                    end else begin
                        if (w_busy < CW'(lprb_pkg::HDR_BYTES)) begin
                            w_status = lprb_pkg::ST_NO_ROOM;
                        end else if (r_hdr[lprb_pkg::HDR_W-1] || r_hdr == '0) begin
                            w_status = lprb_pkg::ST_BAD_LEN;
                        end else if (w_busy32 < r_hdr) begin
                            w_status = lprb_pkg::ST_NO_ROOM;
                        end else begin
                            w_kind = lprb_pkg::KIND_PACKET;
                            w_rem  = r_hdr[CW-1:0];
                        end
                    end
                end else if (!(r_kind == w_pop_kind && r_rem != '0)) begin
                    w_status = lprb_pkg::ST_DISCARD;
                end
                // an empty ring never pops, even with a block open
                if (w_status == lprb_pkg::ST_OK && w_busy == '0) begin
                    w_status = lprb_pkg::ST_DISCARD;
                    w_kind   = lprb_pkg::KIND_NONE;
                    w_rem    = '0;
                end
                if (w_status == lprb_pkg::ST_OK) begin
                    w_do_pop = 1'b1;
                    w_rem    = w_rem - CW'(1);
                    if (w_rem == '0) begin
                        w_kind = lprb_pkg::KIND_NONE;
                        w_last = 1'b1;
                    end
                end
            end
            default: begin
                w_status = lprb_pkg::ST_OK;
            end
        endcase
    end

    // memory port: the item's own access, then four header reads when a byte moves
    always_comb begin
        o_mem_we    = w_accept && w_do_push;
        o_mem_wdata = i_req.data_byte;
        if (r_state == S_IDLE) begin
            o_mem_addr = w_do_push ? r_wp : r_rp;
        end else begin
            o_mem_addr = r_hp;
        end
    end

    // header after this step and fill report
    always_comb begin
        w_hdr_new   = r_rd ? {i_mem_rdata, r_hdr[23:0]} : r_hdr;
        w_hdr_out   = (w_busy >= CW'(lprb_pkg::HDR_BYTES)) ? w_hdr_new : '0;
        w_pkt_ready = (w_busy >= CW'(lprb_pkg::HDR_BYTES)) &&
                      !w_hdr_new[lprb_pkg::HDR_W-1] && (w_hdr_new != '0) &&
                      (w_hdr_new <= w_busy32);
    end

    assign w_load = (r_state == S_FIN) && (!r_ovalid || o_rsp.ready);

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_hp     = r_hp;
        n_kind   = r_kind;
        n_rem    = r_rem;
        n_rd     = r_rd;
        n_hdr    = r_hdr;
        n_status = r_status;
        n_last   = r_last;
        n_pop    = r_pop;
        n_obyte  = r_obyte;
        n_ovalid = r_ovalid;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = w_kind;
                    n_rem    = w_rem;
                    n_status = w_status;
                    n_last   = w_last;
                    n_pop    = w_do_pop;
                    n_obyte  = '0;
                    n_rd     = w_do_push || w_do_pop;
                    if (w_do_push) begin
                        n_wp = advance(r_wp, i_ring);
                    end
                    if (w_do_pop) begin
                        n_rp = advance(r_rp, i_ring);
                        n_hp = advance(r_rp, i_ring);
                    end else begin
                        n_hp = r_rp;
                    end
                    n_state = (w_do_push || w_do_pop) ? S_H0 : S_FIN;
                end
            end
            S_H0: begin
                if (r_pop) begin
                    n_obyte = i_mem_rdata;
                end
                n_hp    = advance(r_hp, i_ring);
                n_state = S_H1;
            end
            S_H1: begin
                n_hdr[7:0] = i_mem_rdata;
                n_hp       = advance(r_hp, i_ring);
                n_state    = S_H2;
            end
            S_H2: begin
                n_hdr[15:8] = i_mem_rdata;
                n_hp        = advance(r_hp, i_ring);
                n_state     = S_H3;
            end
            S_H3: begin
                n_hdr[23:16] = i_mem_rdata;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (w_load) begin
                    n_hdr    = w_hdr_new;
                    n_rd     = 1'b0;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a size write empties the ring
        if (i_clear) begin
            n_rp   = '0;
            n_wp   = '0;
            n_kind = lprb_pkg::KIND_NONE;
            n_rem  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_kind   <= lprb_pkg::KIND_NONE;
            r_rem    <= '0;
            r_rd     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_kind   <= n_kind;
            r_rem    <= n_rem;
            r_rd     <= n_rd;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hp     <= n_hp;
        r_hdr    <= n_hdr;
        r_status <= n_status;
        r_last   <= n_last;
        r_pop    <= n_pop;
        r_obyte  <= n_obyte;
        if (w_load) begin
            r_o_status <= r_status;
            r_o_byte   <= r_obyte;
            r_o_last   <= r_last;
            r_o_busy   <= w_busy32[lprb_pkg::BUSY_W-1:0];
            r_o_free   <= w_free32[lprb_pkg::FREE_W-1:0];
            r_o_hdr    <= w_hdr_out;
            r_o_ready  <= w_pkt_ready;
        end
    end

    // result transfer
    assign o_rsp.valid              = r_ovalid;
    assign o_rsp.status             = r_o_status;
    assign o_rsp.out_byte           = r_o_byte;
    assign o_rsp.last_byte          = r_o_last;
    assign o_rsp.busy_count         = r_o_busy;
    assign o_rsp.free_count         = r_o_free;
    assign o_rsp.next_packet_length = $signed(r_o_hdr);
    assign o_rsp.packet_ready       = r_o_ready;
endmodule

>>> hdl/length_prefixed_packet_ring_buffer.sv
// Byte ring buffer with length-prefixed packets. Each request transfer carries
// one byte command (push, pop, packet pop, status) and yields exactly one result
// transfer with the status, the popped byte and the fill report. All bytes live
// in one single-port memory with registered read data. An item that moves a
// byte makes one memory access for the byte itself, then four memory reads for
// the packet header now at the read pointer, then loads the result register once
// that register is free. An item that moves nothing (status only, rejected or
// discarded) goes straight to loading the result register, as the cached header
// still holds. A new request is taken while an earlier result still waits in the
// result register. Writing buffer_size (clamped to 5 up to BUFFER_BYTES) empties
// the ring at once; no clearing pass follows reset.
module length_prefixed_packet_ring_buffer #(
    parameter int BUFFER_BYTES = lprb_pkg::BUFFER_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lprb_req_if.sink                          i_req,
    lprb_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lprb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lprb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lprb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [CW-1:0]                 w_ring;
    logic                          w_clear;
    logic                          w_mem_we;
    logic [AW-1:0]                 w_mem_addr;
    logic [lprb_pkg::BYTE_W-1:0]   w_mem_wdata;
    logic [lprb_pkg::BYTE_W-1:0]   w_mem_rdata;

    // size register
    lprb_cfg #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ring  (w_ring),
        .o_clear (w_clear)
    );

    // command sequencer
    lprb_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_ring      (w_ring),
        .i_clear     (w_clear),
        .o_mem_we    (w_mem_we),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    // byte store
    lprb_mem #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );
endmodule
